// ===== sv/multi_relay_watchdog_controller_core_defines.svh =====
// ----------------------------------------------------------------------------
// multi relay watchdog controller assertion macros
// shared check macros, clocked on aclk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef MULTI_RELAY_WATCHDOG_CONTROLLER_CORE_DEFINES_SVH
`define MULTI_RELAY_WATCHDOG_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define MRWD_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mrwd check failed");

// next-cycle implication
`define MRWD_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mrwd next-cycle check failed");

`endif

// ===== sv/mrwd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwd_pkg
// types, codes and helpers shared by the relay watchdog controller
// ----------------------------------------------------------------------------
package mrwd_pkg;

    localparam int RELAY_COUNT = 4;
    localparam int IDX_W       = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;
    localparam int OUT_W       = 8;
    localparam int MS_W        = 26;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [MS_W-1:0] MS_PER_S  = MS_W'(1000);
    localparam logic [MS_W-1:0] COUNT_MAX = '1;

    // commands
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_PING     = 3'd1;
    localparam logic [2:0] CMD_SET_MODE = 3'd2;
    localparam logic [2:0] CMD_MANUAL   = 3'd3;
    localparam logic [2:0] CMD_TIMED_ON = 3'd4;
    localparam logic [2:0] CMD_TEMP     = 3'd5;

    // relay modes
    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_WD     = 2'd1;
    localparam logic [1:0] MODE_THERMO = 2'd2;
    localparam logic [1:0] MODE_WD_INV = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESTART = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HYST    = 2'd3;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [2:0]        relay_index;
        logic [1:0]        new_mode;
        logic              manual_on;
        logic [15:0]       seconds;
        logic signed [7:0] temp_c;
    } in_word_t;

    typedef struct packed {
        logic [OUT_W-1:0] relay_levels;
        logic [OUT_W-1:0] relay_tripped;
        logic             pong;
        logic             ignored;
    } out_word_t;

    // decoded operation broadcast to every relay
    typedef struct packed {
        logic            tick;
        logic            ping;
        logic            set_mode;
        logic            man_set;
        logic            timed_on;
        logic            temp_smp;
        logic            temp_hot;
        logic            temp_cold;
        logic [1:0]      new_mode;
        logic            level;
        logic [MS_W-1:0] timer_ms;
    } mrwd_op_t;

    typedef struct packed {
        logic [MS_W-1:0]   timeout_ms;
        logic [MS_W-1:0]   restart_ms;
        logic signed [8:0] on_thr;
        logic signed [8:0] off_thr;
    } mrwd_cfg_t;

    function automatic logic [MS_W-1:0] ms_of(input logic [15:0] secs);
        return MS_W'(secs) * MS_PER_S;
    endfunction

    function automatic logic is_wd(input logic [1:0] mode);
        return (mode == MODE_WD) || (mode == MODE_WD_INV);
    endfunction

endpackage

// ===== sv/mrwd_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwd_cfg
// configuration registers for millisecond limits and fan thresholds
// ----------------------------------------------------------------------------
module mrwd_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [mrwd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrwd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output mrwd_pkg::mrwd_cfg_t              cfg
);

    logic [mrwd_pkg::MS_W-1:0] timeout_ms_reg;
    logic [mrwd_pkg::MS_W-1:0] restart_ms_reg;
    logic signed [7:0]         target_reg;
    logic [4:0]                hyst_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ms_reg <= mrwd_pkg::ms_of(16'd30);
            restart_ms_reg <= mrwd_pkg::ms_of(16'd5);
            target_reg     <= 8'sd40;
            hyst_reg       <= 5'd3;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mrwd_pkg::REG_TIMEOUT: timeout_ms_reg <= mrwd_pkg::ms_of(cfg_wdata);
                mrwd_pkg::REG_RESTART: restart_ms_reg <= mrwd_pkg::ms_of(cfg_wdata);
                mrwd_pkg::REG_TARGET:  target_reg     <= cfg_wdata[7:0];
                mrwd_pkg::REG_HYST:    hyst_reg       <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // thresholds in 9 bits
    assign cfg.timeout_ms = timeout_ms_reg;
    assign cfg.restart_ms = restart_ms_reg;
    assign cfg.on_thr     = $signed({target_reg[7], target_reg}) + $signed({4'b0000, hyst_reg});
    assign cfg.off_thr    = $signed({target_reg[7], target_reg}) - $signed({4'b0000, hyst_reg});

endmodule

// ===== sv/mrwd_relay.sv =====
`timescale 1ns / 1ps
`include "multi_relay_watchdog_controller_core_defines.svh"
// ----------------------------------------------------------------------------
// mrwd_relay
// state and next-state logic of one relay: mode, level, trip and timers
// ----------------------------------------------------------------------------
module mrwd_relay (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 wd_restart,
    input  logic                 sel,
    input  mrwd_pkg::mrwd_op_t   op,
    input  mrwd_pkg::mrwd_cfg_t  cfg,
    output logic                 relay_on_next,
    output logic                 tripped_next,
    output logic                 refuse
);

    logic [1:0]                mode_reg, mode_next;
    logic                      on_reg, on_next;
    logic                      trip_reg, trip_next;
    logic [mrwd_pkg::MS_W-1:0] el_reg, el_next;
    logic [mrwd_pkg::MS_W-1:0] rem_reg, rem_next;
    logic                      manual_now;
    logic                      idle;

    assign manual_now = (mode_reg == mrwd_pkg::MODE_DIRECT);

    always_comb begin
        mode_next = mode_reg;
        on_next   = on_reg;
        trip_next = trip_reg;
        el_next   = el_reg;
        rem_next  = rem_reg;

        if (op.tick) begin
            if (mrwd_pkg::is_wd(mode_reg)) begin
                if (el_reg != mrwd_pkg::COUNT_MAX) begin
                    el_next = el_reg + mrwd_pkg::MS_W'(1);
                end
            end else if (manual_now && rem_reg != '0) begin
                rem_next = rem_reg - mrwd_pkg::MS_W'(1);
                if (rem_reg == mrwd_pkg::MS_W'(1)) begin
                    on_next = 1'b0;
                end
            end
        end
        if (op.ping && mrwd_pkg::is_wd(mode_reg)) begin
            el_next   = '0;
            trip_next = 1'b0;
            on_next   = (mode_reg == mrwd_pkg::MODE_WD);
        end
        if (sel && op.set_mode) begin
            mode_next = op.new_mode;
            rem_next  = '0;
            trip_next = 1'b0;
            el_next   = '0;
            on_next   = (op.new_mode == mrwd_pkg::MODE_WD);
        end
        if (sel && op.man_set && manual_now) begin
            on_next  = op.level;
            rem_next = '0;
        end
        if (sel && op.timed_on && manual_now) begin
            on_next  = 1'b1;
            rem_next = op.timer_ms;
        end
        if (op.temp_smp && mode_reg == mrwd_pkg::MODE_THERMO) begin
            if (op.temp_hot) begin
                on_next = 1'b1;
            end else if (op.temp_cold) begin
                on_next = 1'b0;
            end
        end

        // watchdog check after the command
        idle = (mode_next == mrwd_pkg::MODE_WD);
        if (mrwd_pkg::is_wd(mode_next)) begin
            if (trip_next) begin
                if (el_next >= cfg.restart_ms) begin
                    trip_next = 1'b0;
                    el_next   = '0;
                    on_next   = idle;
                end
            end else if (el_next >= cfg.timeout_ms && on_next == idle) begin
                on_next   = !idle;
                trip_next = 1'b1;
                el_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= mrwd_pkg::MODE_DIRECT;
            on_reg   <= 1'b0;
            trip_reg <= 1'b0;
            el_reg   <= '0;
            rem_reg  <= '0;
        end else if (step) begin
            mode_reg <= mode_next;
            on_reg   <= on_next;
            trip_reg <= trip_next;
            el_reg   <= el_next;
            rem_reg  <= rem_next;
        end else if (wd_restart && mrwd_pkg::is_wd(mode_reg) && !trip_reg) begin
            el_reg <= '0;
        end
    end

    assign relay_on_next = on_next;
    assign tripped_next  = trip_next;
    assign refuse        = sel && (op.man_set || op.timed_on) && !manual_now;

    `MRWD_CHECK(a_trip_only_wd, trip_reg, mrwd_pkg::is_wd(mode_reg))
    `MRWD_CHECK(a_timer_only_manual, rem_reg != '0, manual_now)
    `MRWD_CHECK(a_count_only_wd, el_reg != '0, mrwd_pkg::is_wd(mode_reg))

endmodule

// ===== sv/multi_relay_watchdog_controller_core.sv =====
`timescale 1ns / 1ps
`include "multi_relay_watchdog_controller_core_defines.svh"
// path: an accepted word passes the input register, then the result register, before m_valid rises
// throughput: one word per cycle while m_ready takes each result, set by the single relay
//   update stage between the input register and the result register
// reset: synchronous active-low aresetn clears both valid flags, all relay state and
//   loads the register defaults (30 s timeout, 5 s restart, 40 C target, 3 C band)
// ----------------------------------------------------------------------------
// multi_relay_watchdog_controller_core
// relay controller with watchdog, inverted watchdog, fan and manual modes
// ----------------------------------------------------------------------------
module multi_relay_watchdog_controller_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  mrwd_pkg::in_word_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output mrwd_pkg::out_word_t              m_data,
    input  logic                             cfg_we,
    input  logic [mrwd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrwd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic                  in_valid_reg;
    mrwd_pkg::in_word_t    in_data_reg;
    logic                  out_valid_reg;
    mrwd_pkg::out_word_t   out_data_reg;
    mrwd_pkg::out_word_t   out_next;
    mrwd_pkg::mrwd_op_t    op;
    mrwd_pkg::mrwd_cfg_t   cfg;
    logic                  advance;
    logic                  wd_restart;
    logic                  relay_cmd;
    logic                  bad_cmd;
    logic                  in_range;
    logic signed [8:0]     temp9;

    logic [mrwd_pkg::RELAY_COUNT-1:0] on_vec;
    logic [mrwd_pkg::RELAY_COUNT-1:0] trip_vec;
    logic [mrwd_pkg::RELAY_COUNT-1:0] refuse_vec;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_next;
        end
    end

    mrwd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign wd_restart = cfg_we && (cfg_index == mrwd_pkg::REG_TIMEOUT);

    // command decode
    assign temp9    = {in_data_reg.temp_c[7], in_data_reg.temp_c};
    assign in_range = {1'b0, in_data_reg.relay_index} < 4'(mrwd_pkg::RELAY_COUNT);

    always_comb begin
        op           = '0;
        op.new_mode  = in_data_reg.new_mode;
        op.level     = in_data_reg.manual_on;
        op.timer_ms  = mrwd_pkg::ms_of(in_data_reg.seconds);
        op.temp_hot  = (temp9 >= cfg.on_thr);
        op.temp_cold = (temp9 <= cfg.off_thr);
        relay_cmd    = 1'b0;
        bad_cmd      = 1'b0;
        unique case (in_data_reg.cmd)
            mrwd_pkg::CMD_TICK:     op.tick = 1'b1;
            mrwd_pkg::CMD_PING:     op.ping = 1'b1;
            mrwd_pkg::CMD_SET_MODE: begin
                op.set_mode = 1'b1;
                relay_cmd   = 1'b1;
            end
            mrwd_pkg::CMD_MANUAL: begin
                op.man_set = 1'b1;
                relay_cmd  = 1'b1;
            end
            mrwd_pkg::CMD_TIMED_ON: begin
                op.timed_on = 1'b1;
                relay_cmd   = 1'b1;
            end
            mrwd_pkg::CMD_TEMP:     op.temp_smp = 1'b1;
            default:                bad_cmd = 1'b1;
        endcase
    end

    for (genvar g = 0; g < mrwd_pkg::RELAY_COUNT; g++) begin : g_relay
        mrwd_relay u_relay (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .step          (advance),
            .wd_restart    (wd_restart),
            .sel           (in_data_reg.relay_index == 3'(g)),
            .op            (op),
            .cfg           (cfg),
            .relay_on_next (on_vec[g]),
            .tripped_next  (trip_vec[g]),
            .refuse        (refuse_vec[g])
        );
    end

    always_comb begin
        out_next               = '0;
        out_next.relay_levels  = mrwd_pkg::OUT_W'(on_vec);
        out_next.relay_tripped = mrwd_pkg::OUT_W'(trip_vec);
        out_next.pong          = op.ping;
        out_next.ignored       = bad_cmd || (relay_cmd && !in_range) || (|refuse_vec);
    end

    `MRWD_CHECK(a_stall_cause, !s_ready, in_valid_reg && out_valid_reg && !m_ready)
    `MRWD_CHECK_NEXT(a_ping_pong, advance && in_data_reg.cmd == mrwd_pkg::CMD_PING, m_data.pong)
    `MRWD_CHECK(a_pong_not_ignored, m_valid, !(m_data.pong && m_data.ignored))

endmodule
